[rtl/vdht_pkg.sv]
// shared constants for the vertex deduplication hash table
package vdht_pkg;

    // default sizes
    localparam int VERTEX_WORDS_DEF = 64;
    localparam int MAX_VERTICES_DEF = 1024;

    // fnv-1a 64 constants; prime = 2^40 + 0x1b3
    localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;

    // command codes carried on tuser
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_NEW   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // field widths
    localparam int IDX_OUT_W  = 10;
    localparam int COLL_W     = 32;
    localparam int OUT_DATA_W = 48;

endpackage

[rtl/vdht_ram.sv]
// generic simple dual port ram with registered read
module vdht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/vertex_dedup_hash_table.sv]
// top level of the vertex deduplication hash table
//
// channel | dir | handshake         | contents
// s_      | in  | s_tvalid/s_tready | s_tdata data_word, s_tuser op, s_tlast last_word
// m_      | out | m_tvalid/m_tready | m_tdata vertex_index, store_full, collision_count
//
// a data word is taken in idle, then folded in the shared fnv byte unit, one byte a
//   cycle; a command is carried out on acceptance, with no further states
// a short vertex is zero padded: each missing word is folded and staged as zero
// the end-of-vertex search reads then compares each hash entry scanned and each word
//   compared; an append copies the vertex word by word, a read then a write; a done state
//   hands over the result; s_tready is high only while the sequencer is idle; a finished
//   result waits in the output register, the next transaction is taken meanwhile
// no clearing pass after reset: stores are only read below the fill count
module vertex_dedup_hash_table #(
    parameter int VERTEX_WORDS = vdht_pkg::VERTEX_WORDS_DEF,
    parameter int MAX_VERTICES = vdht_pkg::MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_word[31:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [vdht_pkg::OUT_DATA_W-1:0] m_tdata  // vertex_index[9:0], store_full[10],
                                                     // collision_count[42:11], zero pad
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int WP_W   = $clog2(VERTEX_WORDS + 1);
    localparam int WI_W   = (VERTEX_WORDS > 1) ? $clog2(VERTEX_WORDS) : 1;
    localparam int VA_W   = $clog2(MAX_VERTICES * VERTEX_WORDS);
    localparam int BASE_W = $clog2(MAX_VERTICES * VERTEX_WORDS + 1);
    localparam int COLLW  = vdht_pkg::COLL_W;
    localparam logic [WP_W-1:0]   VW_LAST = WP_W'(VERTEX_WORDS - 1);
    localparam logic [BASE_W-1:0] VW_STEP = BASE_W'(VERTEX_WORDS);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_VERTICES);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,  // waiting for a transaction
        S_HASH  = 10'b00_0000_0010,  // fold the four bytes of a word
        S_PAD   = 10'b00_0000_0100,  // fold zero words of a short vertex
        S_HREAD = 10'b00_0000_1000,  // read hash entry
        S_HCMP  = 10'b00_0001_0000,  // compare hash entry
        S_CREAD = 10'b00_0010_0000,  // read stored and staged word
        S_CCMP  = 10'b00_0100_0000,  // compare stored and staged word
        S_CPRD  = 10'b00_1000_0000,  // read staged word for append
        S_CPWR  = 10'b01_0000_0000,  // write staged word to store
        S_DONE  = 10'b10_0000_0000   // hand result to output register
    } state_t;

    state_t              state_reg, state_next;
    logic [63:0]         hash_reg, hash_next;
    logic [31:0]         wsh_reg, wsh_next;       // word being folded, low byte first
    logic [1:0]          bsel_reg, bsel_next;     // byte counter
    logic                last_reg, last_next;
    logic [WP_W-1:0]     wpos_reg, wpos_next;     // staged word position
    logic [CNT_W-1:0]    count_reg, count_next;   // stored vertices
    logic [COLLW-1:0]    coll_reg, coll_next;
    logic [CNT_W-1:0]    i_reg, i_next;           // entry under test
    logic [BASE_W-1:0]   base_reg, base_next;     // i * VERTEX_WORDS
    logic [WP_W-1:0]     j_reg, j_next;           // word under test
    logic                phase_reg, phase_next;   // 0 hash hit check, 1 linear search
    logic [CNT_W-1:0]    index_reg, index_next;
    logic                full_reg, full_next;
    logic                m_valid_reg, m_valid_next;
    logic [vdht_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // shared fnv unit: one byte per cycle, multiply by prime as shift plus small product
    logic [7:0]  fnv_byte;
    logic [63:0] fnv_x;
    logic [63:0] fnv_out;

    assign fnv_byte = state_reg == S_PAD ? 8'd0 : wsh_reg[7:0];
    assign fnv_x    = hash_reg ^ {56'd0, fnv_byte};
    assign fnv_out  = (fnv_x << vdht_pkg::FNV_PRIME_SHIFT) + fnv_x * vdht_pkg::FNV_PRIME_LO;

    // memories
    logic             stg_we;
    logic [WI_W-1:0]  stg_waddr;
    logic [31:0]      stg_wdata;
    logic [31:0]      stg_rdata;
    logic             vtx_we;
    logic [VA_W-1:0]  vtx_addr;
    logic [31:0]      vtx_rdata;
    logic             hsh_we;
    logic [63:0]      hsh_rdata;
    logic [BASE_W-1:0] vaddr_sum;

    assign vaddr_sum = base_reg + BASE_W'(j_reg);
    assign vtx_addr  = vaddr_sum[VA_W-1:0];

    vdht_ram #(.WIDTH(32), .DEPTH(VERTEX_WORDS)) u_stage (
        .aclk  (aclk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (j_reg[WI_W-1:0]),
        .rdata (stg_rdata)
    );

    vdht_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES * VERTEX_WORDS)) u_vertex (
        .aclk  (aclk),
        .we    (vtx_we),
        .waddr (vtx_addr),
        .wdata (stg_rdata),
        .raddr (vtx_addr),
        .rdata (vtx_rdata)
    );

    vdht_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_hash (
        .aclk  (aclk),
        .we    (hsh_we),
        .waddr (i_reg[IDX_W-1:0]),
        .wdata (hash_reg),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (hsh_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    logic s_fire;
    logic out_free;
    logic scan_end;   // no entries left: append or report full

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        wsh_next     = wsh_reg;
        bsel_next    = bsel_reg;
        last_next    = last_reg;
        wpos_next    = wpos_reg;
        count_next   = count_reg;
        coll_next    = coll_reg;
        i_next       = i_reg;
        base_next    = base_reg;
        j_next       = j_reg;
        phase_next   = phase_reg;
        index_next   = index_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        stg_we       = 1'b0;
        stg_waddr    = wpos_reg[WI_W-1:0];
        stg_wdata    = s_tdata;
        vtx_we       = 1'b0;
        hsh_we       = 1'b0;
        scan_end     = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        vdht_pkg::OP_DATA: begin
                            stg_we     = 1'b1;
                            wsh_next   = s_tdata;
                            last_next  = s_tlast;
                            bsel_next  = 2'd0;
                            state_next = S_HASH;
                        end
                        vdht_pkg::OP_NEW: begin
                            count_next = '0;
                            wpos_next  = '0;
                            hash_next  = vdht_pkg::FNV_BASIS;
                        end
                        vdht_pkg::OP_CLEAR: begin
                            count_next = '0;
                            coll_next  = '0;
                            wpos_next  = '0;
                            hash_next  = vdht_pkg::FNV_BASIS;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HASH: begin
                hash_next = fnv_out;
                wsh_next  = {8'd0, wsh_reg[31:8]};
                bsel_next = bsel_reg + 2'd1;
                if (bsel_reg == 2'd3) begin
                    wpos_next = wpos_reg + WP_W'(1);
                    i_next     = '0;
                    base_next  = '0;
                    phase_next = 1'b0;
                    if (wpos_reg == VW_LAST) begin
                        state_next = S_HREAD;
                    end else if (last_reg) begin
                        state_next = S_PAD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                hash_next = fnv_out;
                bsel_next = bsel_reg + 2'd1;
                if (bsel_reg == 2'd3) begin
                    stg_we    = 1'b1;
                    stg_wdata = 32'd0;
                    wpos_next = wpos_reg + WP_W'(1);
                    if (wpos_reg == VW_LAST) begin
                        state_next = S_HREAD;
                    end
                end
            end
            S_HREAD: begin
                if (i_reg == count_reg) begin
                    scan_end = 1'b1;
                end else begin
                    state_next = S_HCMP;
                end
            end
            S_HCMP: begin
                if (hsh_rdata == hash_reg) begin
                    j_next     = '0;
                    state_next = S_CREAD;
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    base_next  = base_reg + VW_STEP;
                    state_next = S_HREAD;
                end
            end
            S_CREAD: begin
                if (phase_reg && i_reg == count_reg) begin
                    scan_end = 1'b1;
                end else begin
                    state_next = S_CCMP;
                end
            end
            S_CCMP: begin
                if (vtx_rdata != stg_rdata) begin
                    j_next     = '0;
                    state_next = S_CREAD;
                    if (!phase_reg) begin
                        // hash hit with different vertex
                        coll_next  = coll_reg + COLLW'(1);
                        phase_next = 1'b1;
                        i_next     = '0;
                        base_next  = '0;
                    end else begin
                        i_next    = i_reg + CNT_W'(1);
                        base_next = base_reg + VW_STEP;
                    end
                end else if (j_reg == VW_LAST) begin
                    index_next = i_reg;
                    full_next  = 1'b0;
                    state_next = S_DONE;
                end else begin
                    j_next     = j_reg + WP_W'(1);
                    state_next = S_CREAD;
                end
            end
            S_CPRD: begin
                state_next = S_CPWR;
            end
            S_CPWR: begin
                vtx_we = 1'b1;
                if (j_reg == VW_LAST) begin
                    index_next = count_reg;
                    full_next  = 1'b0;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    j_next     = j_reg + WP_W'(1);
                    state_next = S_CPRD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, coll_reg, full_reg,
                                    vdht_pkg::IDX_OUT_W'(index_reg)};
                    hash_next    = vdht_pkg::FNV_BASIS;
                    wpos_next    = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // i equals count here, so base already points at the free slot
        if (scan_end) begin
            if (count_reg != CNT_MAX) begin
                hsh_we     = 1'b1;
                j_next     = '0;
                state_next = S_CPRD;
            end else begin
                index_next = '0;
                full_next  = 1'b1;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hash_reg    <= vdht_pkg::FNV_BASIS;
            wpos_reg    <= '0;
            count_reg   <= '0;
            coll_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            wpos_reg    <= wpos_next;
            count_reg   <= count_next;
            coll_reg    <= coll_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wsh_reg    <= wsh_next;
        bsel_reg   <= bsel_next;
        last_reg   <= last_next;
        i_reg      <= i_next;
        base_reg   <= base_next;
        j_reg      <= j_next;
        phase_reg  <= phase_next;
        index_reg  <= index_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

    // fill count never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("stored count beyond capacity");

    // a full store reports index zero
    a_full_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[9:0] == 10'd0)
        else $error("full result with nonzero index");

    // collision counter only steps by one or clears
    a_coll_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 coll_reg != $past(coll_reg) |->
            coll_reg == $past(coll_reg) + COLLW'(1) || coll_reg == '0)
        else $error("collision counter jumped");

    // a new result is loaded only when the output slot is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg && $stable(m_data_reg))
        else $error("pending result overwritten");

endmodule

[bench/tb.sv]
// self-checking testbench for the vertex deduplication hash table
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWORDS = vdht_pkg::VERTEX_WORDS_DEF;
    localparam int NVERT = vdht_pkg::MAX_VERTICES_DEF;
    localparam logic [63:0] PRIME = 64'd1099511628211;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, block ignores it
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct packed {
        logic [9:0]  index;
        logic        full;
        logic [31:0] coll;
    } lookup_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = vdht_pkg::OP_DATA;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [vdht_pkg::OUT_DATA_W-1:0] m_tdata;

    vertex_dedup_hash_table u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state mirrors the block
    logic [31:0] vstore [NVERT][NWORDS];
    logic [63:0] hstore [NVERT];
    int          n_stored = 0;
    logic [31:0] coll_cnt = '0;
    logic [63:0] run_hash = vdht_pkg::FNV_BASIS;
    logic [31:0] stage [NWORDS];
    int          wpos = 0;

    lookup_t expected_q[$];
    int      n_errors = 0;
    bit      quiet = 1'b0;   // no idling on either side while set
    longint  cycles = 0;

    function automatic logic [63:0] fnv_word(logic [63:0] h, logic [31:0] w);
        for (int b = 0; b < 4; b++) begin
            h = (h ^ {56'd0, w[8*b +: 8]}) * PRIME;
        end
        return h;
    endfunction

    function automatic bit stage_equals(int idx);
        for (int k = 0; k < NWORDS; k++) begin
            if (vstore[idx][k] !== stage[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // run one accepted transaction through the predictor
    task automatic dedup_predict(logic [1:0] op, logic [31:0] word, logic last);
        logic [63:0] h;
        int          hit;
        lookup_t     r;
        if (op == vdht_pkg::OP_NEW || op == vdht_pkg::OP_CLEAR) begin
            if (op == vdht_pkg::OP_CLEAR) coll_cnt = '0;
            n_stored = 0;
            run_hash = vdht_pkg::FNV_BASIS;
            wpos = 0;
            return;
        end
        if (op != vdht_pkg::OP_DATA) return;
        stage[wpos] = word;
        run_hash = fnv_word(run_hash, word);
        wpos++;
        if (!last && wpos < NWORDS) return;
        // short vertex: zero padding counts for hash and storage
        while (wpos < NWORDS) begin
            stage[wpos] = '0;
            run_hash = fnv_word(run_hash, '0);
            wpos++;
        end
        h = run_hash;
        run_hash = vdht_pkg::FNV_BASIS;
        wpos = 0;
        hit = -1;
        r = '0;
        for (int i = 0; i < n_stored; i++) begin
            if (hstore[i] == h) begin
                hit = i;
                break;
            end
        end
        if (hit >= 0 && !stage_equals(hit)) begin
            // hash collision, fall back to a linear search
            coll_cnt++;
            hit = -1;
            for (int i = 0; i < n_stored; i++) begin
                if (stage_equals(i)) begin
                    hit = i;
                    break;
                end
            end
        end
        if (hit >= 0) begin
            r.index = hit[9:0];
        end else if (n_stored < NVERT) begin
            r.index = n_stored[9:0];
            for (int k = 0; k < NWORDS; k++) vstore[n_stored][k] = stage[k];
            hstore[n_stored] = h;
            n_stored++;
        end else begin
            r.full = 1'b1;
        end
        r.coll = coll_cnt;
        expected_q = {expected_q, r};
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[9:0] !== want.index)
                    report_mismatch("vertex_index", 32'(m_tdata[9:0]), 32'(want.index));
                if (m_tdata[10] !== want.full)
                    report_mismatch("store_full", 32'(m_tdata[10]), 32'(want.full));
                if (m_tdata[42:11] !== want.coll)
                    report_mismatch("collision_count", m_tdata[42:11], want.coll);
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // send one transaction; entered and left at a falling edge
    task automatic send_item(logic [1:0] op, logic [31:0] word, logic last);
        if (!quiet && $urandom_range(99) < 7) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = word;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        dedup_predict(op, word, last);
        @(negedge aclk);
    endtask

    // words beyond len are not sent; mark selects tlast on the final one
    task automatic send_vertex(logic [31:0] w [NWORDS], int len, bit mark);
        for (int k = 0; k < len; k++)
            send_item(vdht_pkg::OP_DATA, w[k], mark && k == len - 1);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (expected_q.size() == 0);
        repeat (300) @(negedge aclk);
    endtask

    task automatic test_directed();
        logic [31:0] w [NWORDS];
        quiet = 1'b1;
        foreach (w[k]) w[k] = '0;
        w[0] = 32'hFFFF_FFFF;
        send_vertex(w, 1, 1'b1);              // new index 0
        w[2] = 32'h0;
        send_vertex(w, 3, 1'b1);              // explicit zeros equal the padded one
        w[0] = 32'h0;
        send_vertex(w, 1, 1'b1);              // all-zero vertex
        foreach (w[k]) w[k] = 32'hA5A5_0000 | k;
        send_vertex(w, NWORDS, 1'b0);         // full length without tlast
        send_item(OP_SPARE, 32'hDEAD_BEEF, 1'b1);
        send_vertex(w, NWORDS, 1'b1);         // same vertex, with tlast
        send_item(vdht_pkg::OP_DATA, 32'h1234_5678, 1'b0);
        send_item(vdht_pkg::OP_NEW, '0, 1'b0);          // drops the partial vertex
        send_vertex(w, 2, 1'b1);
        send_item(vdht_pkg::OP_DATA, 32'h0000_0001, 1'b0);
        send_item(vdht_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_vertex(w, 2, 1'b1);
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_store_full();
        logic [31:0] w [NWORDS];
        foreach (w[k]) w[k] = '0;
        send_item(vdht_pkg::OP_CLEAR, '0, 1'b0);
        for (int i = 0; i <= NVERT; i++) begin
            w[0] = 32'h8000_0000 + i;
            send_vertex(w, 1, 1'b1);          // the last one overflows
        end
        w[0] = 32'h8000_0005;
        send_vertex(w, 1, 1'b1);              // still found while full
        drain();
    endtask

    task automatic test_random(int n_items);
        logic [31:0] pool [8][NWORDS];
        int          plen [8];
        logic [31:0] w [NWORDS];
        int          sent, len, p, pick;
        for (int j = 0; j < 8; j++) begin
            plen[j] = $urandom_range(1, 6);
            foreach (w[k]) pool[j][k] = (k < plen[j]) ? $urandom : '0;
        end
        sent = 0;
        while (sent < n_items) begin
            quiet = (sent > n_items / 2 && sent < n_items / 2 + 150);
            pick = $urandom_range(99);
            if (pick < 45) begin
                // repeat a pooled vertex, sometimes with extra zero words
                p = $urandom_range(7);
                len = plen[p] + ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
                if (len > NWORDS) len = NWORDS;
                foreach (w[k]) w[k] = pool[p][k];
                send_vertex(w, len, 1'b1);
                sent += len;
            end else if (pick < 80) begin
                len = ($urandom_range(19) == 0) ? NWORDS : $urandom_range(1, 8);
                foreach (w[k]) w[k] = $urandom;
                if ($urandom_range(3) == 0) begin
                    p = $urandom_range(7);
                    plen[p] = len;
                    foreach (w[k]) pool[p][k] = (k < len) ? w[k] : '0;
                end
                send_vertex(w, len, len < NWORDS || $urandom_range(1) != 0);
                sent += len;
            end else if (pick < 90) begin
                // broken vertex cut short by a command
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) send_item(vdht_pkg::OP_DATA, $urandom, 1'b0);
                send_item($urandom_range(1) != 0 ? vdht_pkg::OP_NEW : vdht_pkg::OP_CLEAR,
                          $urandom, 1'($urandom_range(1)));
                sent += len + 1;
            end else if (pick < 95) begin
                send_item(vdht_pkg::OP_NEW, $urandom, 1'($urandom_range(1)));
                sent++;
            end else begin
                send_item(OP_SPARE, $urandom, 1'($urandom_range(1)));
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(100);
        test_store_full();
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/vdht_pkg.sv
rtl/vdht_ram.sv
rtl/vertex_dedup_hash_table.sv
bench/tb.sv
